// ===== rtl/dbef_pkg.sv =====
// Shared constants, codes and transaction types for the debounced button event FIFO.
`default_nettype none

package dbef_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int QUEUE_DEPTH = 16;

  localparam int BTN_IDX_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int SLOT_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int LEVELS_W   = 8;
  localparam int TICK_W     = 32;
  localparam int LOCKOUT_W  = 16;
  localparam int CAP_W      = 5;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int BTN_W      = 3;
  localparam int QUEUED_W   = 5;
  localparam int TALLY_W    = 4;

  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET  = 16'd100;
  localparam logic [CAP_W-1:0]     CAPACITY_RESET = 5'd10;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCKOUT  = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t                 op;
    logic [LEVELS_W-1:0] levels;
    logic [TICK_W-1:0]   now_tick;
  } cmd_t;

  typedef struct packed {
    logic               event_valid;
    logic [BTN_W-1:0]   event_button;
    logic [QUEUED_W-1:0] queued;
    logic [TALLY_W-1:0] accepted_now;
    logic [TALLY_W-1:0] dropped_now;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dbef_front.sv =====
// Input side: accepts transactions, tags the operation and queues them for the back end.
`default_nettype none

module dbef_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          in_operation,
  input  wire  [dbef_pkg::LEVELS_W-1:0] in_button_levels,
  input  wire  [dbef_pkg::TICK_W-1:0]   in_now_tick,
  output logic                         cmd_valid,
  output dbef_pkg::cmd_t               cmd,
  input  wire                          cmd_take
);
  import dbef_pkg::*;

  localparam int QD = 2;

  cmd_t       q_r [QD];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  cmd_t       in_cmd;

  always_comb begin
    in_cmd.op       = op_t'(in_operation);
    in_cmd.levels   = in_button_levels;
    in_cmd.now_tick = in_now_tick;
  end

  assign in_stall  = (cnt_r == 2'(QD));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dbef_back.sv =====
// Back end: button scan sequencer, lockout timing, event ring and result register.
`default_nettype none

module dbef_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cmd_valid,
  input  wire  dbef_pkg::cmd_t             cmd,
  output logic                             cmd_take,
  input  wire                              cfg_we,
  input  wire  [dbef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [dbef_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output dbef_pkg::result_t                out_res
);
  import dbef_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_POP, S_EMIT} state_t;

  state_t                 state_r;
  cmd_t                   cmd_r;
  logic [BTN_IDX_W-1:0]   idx_r;
  logic [NUM_BUTTONS-1:0] pressed_r;
  logic [TICK_W-1:0]      rel_time_r [NUM_BUTTONS];
  logic [SLOT_W-1:0]      head_r;
  logic [CNT_W-1:0]       count_r;
  logic [LOCKOUT_W-1:0]   lockout_r;
  logic [CAP_W-1:0]       cap_r;
  result_t                res_r;
  result_t                out_r;
  logic                   out_valid_r;

  // event ring
  logic [BTN_W-1:0]       mem [QUEUE_DEPTH];
  logic [BTN_W-1:0]       rd_data_r;
  logic                   mem_we, mem_re;
  logic [SLOT_W-1:0]      wr_slot;

  logic [CNT_W-1:0]       cap_eff;
  logic [CNT_W:0]         slot_sum;
  logic                   lvl, pf, lock_ok, full, last_btn, emit_go;
  logic [TICK_W-1:0]      elapsed;
  logic [SLOT_W-1:0]      head_inc;

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > QUEUE_DEPTH) begin
      cap_eff = CNT_W'(QUEUE_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  always_comb begin
    slot_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
    if (slot_sum >= (CNT_W+1)'(cap_eff)) slot_sum = slot_sum - (CNT_W+1)'(cap_eff);
    wr_slot = SLOT_W'(slot_sum);
  end

  assign head_inc = ((CNT_W'(head_r) + CNT_W'(1)) == cap_eff) ? '0 : head_r + SLOT_W'(1);

  // buttons past the eighth never read as pressed
  assign lvl      = (32'(idx_r) < LEVELS_W) ? cmd_r.levels[3'(idx_r)] : 1'b0;
  assign pf       = pressed_r[idx_r];
  assign elapsed  = cmd_r.now_tick - rel_time_r[idx_r];
  assign lock_ok  = elapsed >= TICK_W'(lockout_r);
  assign full     = count_r >= cap_eff;
  assign last_btn = (idx_r == BTN_IDX_W'(NUM_BUTTONS - 1));
  assign emit_go  = !out_valid_r || !out_stall;

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign mem_we   = (state_r == S_SCAN) && lvl && !pf && lock_ok && !full;
  assign mem_re   = cmd_take && (cmd.op == OP_POP) && (count_r != '0);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_slot] <= BTN_W'(idx_r);
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pressed_r   <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) rel_time_r[i] <= '0;
      head_r      <= '0;
      count_r     <= '0;
      lockout_r   <= LOCKOUT_RESET;
      cap_r       <= CAPACITY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      // the emit state loads the next result itself
      if (out_valid_r && !out_stall && state_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            res_r <= '0;
            idx_r <= '0;
            if (cmd.op == OP_SAMPLE) begin
              state_r <= S_SCAN;
            end else if (count_r != '0) begin
              head_r  <= head_inc;
              count_r <= count_r - CNT_W'(1);
              state_r <= S_POP;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          if (!lvl) begin
            if (pf) begin
              rel_time_r[idx_r] <= cmd_r.now_tick;
              pressed_r[idx_r]  <= 1'b0;
            end
          end else if (!pf && lock_ok) begin
            // a full ring drops the click but the press still latches
            pressed_r[idx_r] <= 1'b1;
            if (!full) begin
              count_r            <= count_r + CNT_W'(1);
              res_r.accepted_now <= res_r.accepted_now + TALLY_W'(1);
            end else begin
              res_r.dropped_now  <= res_r.dropped_now + TALLY_W'(1);
            end
          end
          idx_r <= idx_r + BTN_IDX_W'(1);
          if (last_btn) state_r <= S_EMIT;
        end
        S_POP: begin
          res_r.event_valid  <= 1'b1;
          res_r.event_button <= rd_data_r;
          state_r            <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_r       <= {res_r.event_valid, res_r.event_button, QUEUED_W'(count_r),
                            res_r.accepted_now, res_r.dropped_now};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_LOCKOUT:  lockout_r <= cfg_data[LOCKOUT_W-1:0];
          CFG_CAPACITY: begin
            cap_r   <= cfg_data[CAP_W-1:0];
            head_r  <= '0;
            count_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

// ===== rtl/debounced_button_event_fifo_unit.sv =====
// Top level of the debounced button event FIFO: front queue plus scan back end.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | operation, button_levels, now_tick
//  out_    | output    | out_valid/out_stall| event_valid, event_button, queued,
//          |           |                    | accepted_now, dropped_now
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data (write only)
//
// A sample is taken from the command queue, each button is then checked against its
// release time in the scan state, and the result register is loaded last; the load
// waits while a held result is stalled. A pop reads the event ring through a
// registered read before the result is loaded; a pop on an empty ring skips the
// read and goes straight to loading the result.
// The two-entry command queue accepts until full while the back end scans or its
// result waits on out_stall. Reset is synchronous and needs no clearing pass.
`default_nettype none

module debounced_button_event_fifo_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_operation,
  input  wire  [dbef_pkg::LEVELS_W-1:0]    in_button_levels,
  input  wire  [dbef_pkg::TICK_W-1:0]      in_now_tick,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_event_valid,
  output logic [dbef_pkg::BTN_W-1:0]       out_event_button,
  output logic [dbef_pkg::QUEUED_W-1:0]    out_queued,
  output logic [dbef_pkg::TALLY_W-1:0]     out_accepted_now,
  output logic [dbef_pkg::TALLY_W-1:0]     out_dropped_now,
  input  wire                              cfg_we,
  input  wire  [dbef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [dbef_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dbef_pkg::*;

  logic    cmd_valid, cmd_take;
  cmd_t    cmd;
  result_t res;

  dbef_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_button_levels (in_button_levels),
    .in_now_tick      (in_now_tick),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_take         (cmd_take)
  );

  dbef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_event_valid  = res.event_valid;
  assign out_event_button = res.event_button;
  assign out_queued       = res.queued;
  assign out_accepted_now = res.accepted_now;
  assign out_dropped_now  = res.dropped_now;

endmodule

`default_nettype wire

// ===== rtl/dbef_checker.sv =====
// Port-level checks on the debounced button event FIFO, bound to the top level.
`default_nettype none

module dbef_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_stall,
  input wire                              in_operation,
  input wire [dbef_pkg::LEVELS_W-1:0]     in_button_levels,
  input wire [dbef_pkg::TICK_W-1:0]       in_now_tick,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire                              out_event_valid,
  input wire [dbef_pkg::BTN_W-1:0]        out_event_button,
  input wire [dbef_pkg::QUEUED_W-1:0]     out_queued,
  input wire [dbef_pkg::TALLY_W-1:0]      out_accepted_now,
  input wire [dbef_pkg::TALLY_W-1:0]      out_dropped_now,
  input wire                              cfg_we,
  input wire [dbef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input wire [dbef_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dbef_pkg::*;

  // hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_valid)
      && $stable(out_event_button) && $stable(out_queued)
      && $stable(out_accepted_now) && $stable(out_dropped_now))
    else $error("stalled result changed");

  a_pop_no_tally: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_valid |-> out_accepted_now == '0 && out_dropped_now == '0)
    else $error("popped event carries sample tallies");

  a_empty_button: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_valid |-> out_event_button == '0)
    else $error("button index without event");

  a_queued_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_queued) <= QUEUE_DEPTH)
    else $error("queued count exceeds ring depth");

endmodule

bind debounced_button_event_fifo_unit dbef_checker u_dbef_checker (.*);

`default_nettype wire

// ===== verif/dbef_checker.sv =====
// Scoreboard for the debounced button event FIFO: mirrors the scan and ring, compares results.
module dbef_scoreboard
  import dbef_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_stall,
  input  wire                  in_operation,
  input  wire [LEVELS_W-1:0]   in_button_levels,
  input  wire [TICK_W-1:0]     in_now_tick,
  input  wire                  out_valid,
  input  wire                  out_stall,
  input  wire                  out_event_valid,
  input  wire [BTN_W-1:0]      out_event_button,
  input  wire [QUEUED_W-1:0]   out_queued,
  input  wire [TALLY_W-1:0]    out_accepted_now,
  input  wire [TALLY_W-1:0]    out_dropped_now,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LOCKOUT_W-1:0] lockout;
  logic [CAP_W-1:0]     capacity;
  logic                 held [NUM_BUTTONS];
  logic [TICK_W-1:0]    release_tick [NUM_BUTTONS];
  logic [BTN_W-1:0]     ring [QUEUE_DEPTH];
  int                   ring_head;
  int                   ring_count;
  result_t              expected_q[$];

  function automatic result_t predict_result(op_t op, logic [LEVELS_W-1:0] levels,
                                             logic [TICK_W-1:0] tick);
    result_t           r;
    int                depth;
    int                i;
    logic [TICK_W-1:0] elapsed;
    r = '0;
    // a zero capacity acts as one; settings above the built ring clamp to its depth
    depth = (capacity == 0) ? 1 : (capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(capacity);
    if (op == OP_POP) begin
      if (ring_count > 0) begin
        ring_head = ring_head % depth;
        r.event_valid = 1'b1;
        r.event_button = ring[ring_head];
        ring_head = (ring_head + 1) % depth;
        ring_count--;
      end
    end else begin
      for (i = 0; i < NUM_BUTTONS; i++) begin
        if (!levels[i]) begin
          if (held[i]) begin
            release_tick[i] = tick;
            held[i] = 1'b0;
          end
        end else if (!held[i]) begin
          elapsed = tick - release_tick[i];
          // inside the lockout the edge stays pending for the next sample
          if (elapsed >= {{(TICK_W-LOCKOUT_W){1'b0}}, lockout}) begin
            if (ring_count < depth) begin
              ring[(ring_head + ring_count) % depth] = BTN_W'(i);
              ring_count++;
              r.accepted_now += 1;
            end else begin
              r.dropped_now += 1;
            end
            held[i] = 1'b1;
          end
        end
      end
    end
    r.queued = QUEUED_W'(ring_count);
    return r;
  endfunction

  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    int      i;
    if (!rst_n) begin
      lockout = LOCKOUT_RESET;
      capacity = CAPACITY_RESET;
      for (i = 0; i < NUM_BUTTONS; i++) begin
        held[i] = 1'b0;
        release_tick[i] = '0;
      end
      ring_head = 0;
      ring_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LOCKOUT) begin
          lockout = cfg_data[LOCKOUT_W-1:0];
        end else begin
          // any capacity write empties the ring
          capacity = cfg_data[CAP_W-1:0];
          ring_head = 0;
          ring_count = 0;
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_result(op_t'(in_operation), in_button_levels, in_now_tick));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("event_valid", want.event_valid, out_event_valid);
          compare_field("event_button", want.event_button, out_event_button);
          compare_field("queued", want.queued, out_queued);
          compare_field("accepted_now", want.accepted_now, out_accepted_now);
          compare_field("dropped_now", want.dropped_now, out_dropped_now);
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== verif/tb_debounced_button_event_fifo_unit.sv =====
// Stimulus and verdict for the debounced button event FIFO unit.
module tb_debounced_button_event_fifo_unit
  import dbef_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  op_t                   in_operation;
  logic [LEVELS_W-1:0]   in_button_levels;
  logic [TICK_W-1:0]     in_now_tick;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_event_valid;
  logic [BTN_W-1:0]      out_event_button;
  logic [QUEUED_W-1:0]   out_queued;
  logic [TALLY_W-1:0]    out_accepted_now;
  logic [TALLY_W-1:0]    out_dropped_now;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  bit                    sender_gaps;
  logic [TICK_W-1:0]     tick_now;
  logic [LEVELS_W-1:0]   levels_now;

  debounced_button_event_fifo_unit uut (.*);

  dbef_scoreboard scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_item(op_t op, logic [LEVELS_W-1:0] levels, logic [TICK_W-1:0] tick);
    while (sender_gaps && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_button_levels <= levels;
    in_now_tick <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // let a scan still in flight settle
    repeat (12) @(posedge clk);
  endtask

  task automatic run_phase(int lock, int cap, int items, logic [TICK_W-1:0] start_tick, bit gaps);
    int k;
    int roll;
    quiesce();
    write_reg(CFG_LOCKOUT, CFG_DATA_W'(lock));
    write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
    sender_gaps = gaps;
    tick_now = start_tick;
    for (k = 0; k < items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 38) begin
        send_item(OP_POP, LEVELS_W'($urandom), $urandom);
      end else begin
        // mostly steady time and sparse level toggles; a few jumps and random levels
        if (roll < 43) tick_now = $urandom;
        else if (roll >= 88) tick_now += lock + $urandom_range(0, 50);
        else tick_now += $urandom_range(0, lock / 2 + 4);
        if (roll >= 96) levels_now = LEVELS_W'($urandom);
        else levels_now ^= LEVELS_W'($urandom & $urandom);
        send_item(OP_SAMPLE, levels_now, tick_now);
      end
    end
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_SAMPLE;
    in_button_levels <= '0;
    in_now_tick <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LOCKOUT;
    cfg_data <= '0;
    sender_gaps = 1'b1;
    levels_now = '0;
    tick_now = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: lockout 100, ten entries
    send_item(OP_POP, 8'h00, 32'h0);
    send_item(OP_SAMPLE, 8'hFF, 32'd50);
    send_item(OP_SAMPLE, 8'hFF, 32'd100);
    send_item(OP_SAMPLE, 8'h00, 32'd200);
    send_item(OP_SAMPLE, 8'hFF, 32'd250);
    send_item(OP_SAMPLE, 8'hFF, 32'd300);
    send_item(OP_SAMPLE, 8'hFF, 32'd301);
    repeat (10) send_item(OP_POP, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_SAMPLE, 8'h00, 32'd400);
    send_item(OP_SAMPLE, 8'h00, 32'd500);
    send_item(OP_SAMPLE, 8'h01, 32'hFFFF_FFF0);
    send_item(OP_SAMPLE, 8'h00, 32'hFFFF_FFFF);
    send_item(OP_SAMPLE, 8'h01, 32'h0000_0050);
    send_item(OP_SAMPLE, 8'h81, 32'h0000_0064);

    run_phase(0, 1, 90, 32'h0000_1000, 1'b1);
    run_phase(65535, 16, 90, $urandom, 1'b0);
    run_phase($urandom_range(1, 500), 0, 90, $urandom, 1'b1);
    run_phase($urandom_range(0, 300), 31, 90, 32'hFFFF_F000, 1'b1);
    run_phase($urandom_range(0, 2000), $urandom_range(1, 16), 90, $urandom, 1'b1);

    quiesce();
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : receiver
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      repeat ($urandom_range(150, 300)) @(posedge clk) out_stall <= ($urandom_range(0, 99) < 23);
      repeat ($urandom_range(100, 200)) @(posedge clk) out_stall <= 1'b0;
      // hold off long enough for the command queue to back up into in_stall
      repeat (80) @(posedge clk) out_stall <= 1'b1;
    end
  end

endmodule

// ===== files.f =====
rtl/dbef_pkg.sv
rtl/dbef_front.sv
rtl/dbef_back.sv
rtl/debounced_button_event_fifo_unit.sv
rtl/dbef_checker.sv
verif/dbef_checker.sv
verif/tb_debounced_button_event_fifo_unit.sv
